@@ src/jac3d_pkg.sv @@
// ----------------------------------------------------------------------------
// jac3d_pkg
// Shared types for the seven-point stencil: item tags, results, queue pushes.
// ----------------------------------------------------------------------------
package jac3d_pkg;

    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic signed [31:0] value;
        logic [9:0]         batch;
        logic [11:0]        z;
        logic [5:0]         y;
        logic [5:0]         x;
        logic               last;
    } t_result;

    // tag of one accepted item, travels alongside the arithmetic
    typedef struct packed {
        logic        has0;      // plane behind is emitted
        logic        has1;      // last plane: own boundary copy as well
        logic        interior;
        logic [31:0] cur;
        logic [9:0]  batch;
        logic [11:0] zc;
        logic [11:0] z;
        logic [5:0]  y;
        logic [5:0]  x;
    } t_meta;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

@@ src/jac3d_ram.sv @@
// ----------------------------------------------------------------------------
// jac3d_ram
// Generic RAM: one write port, two read ports, registered read (read-first).
// ----------------------------------------------------------------------------
module jac3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr0,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr1,
    output logic [WIDTH-1:0]                     o_rdata0,
    output logic [WIDTH-1:0]                     o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

@@ src/jac3d_calc.sv @@
// ----------------------------------------------------------------------------
// jac3d_calc
// Weighted sum: products, partial sums, saturated sum; boundary keeps centre.
// ----------------------------------------------------------------------------
module jac3d_calc (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  jac3d_pkg::t_meta       i_meta,
    input  logic signed [31:0]     i_zm,
    input  logic signed [31:0]     i_centre,
    input  logic signed [31:0]     i_ym,
    input  logic signed [31:0]     i_yp,
    input  logic signed [31:0]     i_xm,
    input  logic signed [31:0]     i_xp,
    output jac3d_pkg::t_push       o_push,
    output logic [2:0]             o_pend
);
    import jac3d_pkg::*;

    // Q0.24 weights, sum is exactly one
    localparam logic [23:0] W_ZM = 24'd167772;
    localparam logic [23:0] W_ZP = 24'd335544;
    localparam logic [23:0] W_YM = 24'd503316;
    localparam logic [23:0] W_YP = 24'd671089;
    localparam logic [23:0] W_XM = 24'd838861;
    localparam logic [23:0] W_XP = 24'd1006633;
    localparam logic [23:0] W_C  = 24'd13254001;

    localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
    localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

    // product dropped by 24 bits, i.e. floor
    function automatic logic signed [32:0] weigh(input logic signed [31:0] v,
                                                 input logic [23:0] w);
        logic signed [56:0] p;
        p = v * $signed({1'b0, w});
        return p[56:24];
    endfunction

    logic               r_v1, r_v2, r_v3;
    t_meta              r_m1, r_m2, r_m3;
    logic signed [31:0] r_c2, r_c3;
    logic signed [32:0] r_t [7];
    logic signed [34:0] r_pa, r_pb;

    logic signed [35:0] sum;
    logic signed [31:0] sat;
    t_result            res0, res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (i_accept) begin
            r_m1 <= i_meta;
        end
        r_t[0] <= weigh(i_zm, W_ZM);
        r_t[1] <= weigh($signed(r_m1.cur), W_ZP);
        r_t[2] <= weigh(i_ym, W_YM);
        r_t[3] <= weigh(i_yp, W_YP);
        r_t[4] <= weigh(i_xm, W_XM);
        r_t[5] <= weigh(i_xp, W_XP);
        r_t[6] <= weigh(i_centre, W_C);
        r_m2   <= r_m1;
        r_c2   <= i_centre;
        r_pa   <= 35'(r_t[0]) + 35'(r_t[1]) + 35'(r_t[2]) + 35'(r_t[3]);
        r_pb   <= 35'(r_t[4]) + 35'(r_t[5]) + 35'(r_t[6]);
        r_m3   <= r_m2;
        r_c3   <= r_c2;
    end

    always_comb begin
        sum = 36'(r_pa) + 36'(r_pb);
        if (sum > SAT_HI) begin
            sat = 32'sh7FFFFFFF;
        end else if (sum < SAT_LO) begin
            sat = 32'sh80000000;
        end else begin
            sat = sum[31:0];
        end

        res0.value = r_m3.interior ? sat : r_c3;
        res0.batch = r_m3.batch;
        res0.z     = r_m3.zc;
        res0.y     = r_m3.y;
        res0.x     = r_m3.x;
        res0.last  = ~r_m3.has1;

        res1.value = $signed(r_m3.cur);
        res1.batch = r_m3.batch;
        res1.z     = r_m3.z;
        res1.y     = r_m3.y;
        res1.x     = r_m3.x;
        res1.last  = 1'b1;

        o_push.cnt = r_v3 ? (2'(r_m3.has0) + 2'(r_m3.has1)) : 2'd0;
        o_push.r0  = r_m3.has0 ? res0 : res1;
        o_push.r1  = res1;

        o_pend = (r_v1 ? 3'(r_m1.has0) + 3'(r_m1.has1) : 3'd0)
               + (r_v2 ? 3'(r_m2.has0) + 3'(r_m2.has1) : 3'd0)
               + (r_v3 ? 3'(r_m3.has0) + 3'(r_m3.has1) : 3'd0);
    end

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.cnt == 2'd2 |-> (!o_push.r0.last && o_push.r1.last))
        else $error("pair of results out of order");

endmodule

@@ src/jac3d_outq.sv @@
// ----------------------------------------------------------------------------
// jac3d_outq
// Result queue: up to two results in a cycle, one out a cycle unless stalled.
// ----------------------------------------------------------------------------
module jac3d_outq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  jac3d_pkg::t_push        i_push,
    output logic                    o_valid,
    input  logic                    i_stall,
    output jac3d_pkg::t_result      o_head,
    output logic [jac3d_pkg::Q_AW:0] o_count
);
    import jac3d_pkg::*;

    t_result          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_AW:0]    r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid & ~i_stall;
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + Q_AW'(i_push.cnt);
            r_rp    <= r_rp + Q_AW'(pop);
            r_count <= r_count + (Q_AW + 1)'(i_push.cnt) - (Q_AW + 1)'(pop);
        end
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + Q_AW'(1)] <= i_push.r1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (5'(r_count) + 5'(i_push.cnt) - 5'(pop)) <= 5'(Q_DEPTH))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt == 2'd0 && pop) |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count slip");

endmodule

@@ src/jacobi_stencil_3d_seven_point.sv @@
// ----------------------------------------------------------------------------
// jacobi_stencil_3d_seven_point
// Seven-point Jacobi stencil over streamed 3D volumes, one plane behind input.
// Path: store read, product and partial-sum registers, then the output queue.
// Throughput: one request per cycle while o_stall is low; last-plane requests
// give two results and the output queue drains one per cycle, so input stalls.
// Reads: six plane-store reads per request from three copies of the store.
// Reset: synchronous; counters to zero, sizes to 64/64/64/1; store not cleared.
// ----------------------------------------------------------------------------
module jacobi_stencil_3d_seven_point #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_point_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_value,
    output logic [9:0]         o_out_batch,
    output logic [11:0]        o_out_z,
    output logic [5:0]         o_out_y,
    output logic [5:0]         o_out_x,
    output logic               o_last_of_run,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data
);
    import jac3d_pkg::*;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [1:0] CFG_BATCH  = 2'd3;

    localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int XCW   = $clog2(MAX_X + 1);
    localparam int YCW   = $clog2(MAX_Y + 1);
    localparam int PW    = MAX_X * MAX_Y;
    localparam int DEPTH = 2 * PW;
    localparam int AW    = $clog2(DEPTH);

    logic [6:0]    r_size_x, r_size_y;
    logic [11:0]   r_size_z;
    logic [9:0]    r_batch_count;
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic [11:0]   r_z, n_z;
    logic [9:0]    r_batch, n_batch;

    logic [XCW-1:0] sx;
    logic [YCW-1:0] sy;
    logic [11:0]    sz;
    logic [9:0]     bc;
    logic           accept, x_end, y_end, z_end, b_end;
    logic [AW-1:0]  base, cur_off, prev_off;
    logic [AW-1:0]  a_zm, a_c, a_ym, a_yp, a_xm, a_xp;
    t_meta          meta;

    logic signed [31:0] d_zm, d_c, d_ym, d_yp, d_xm, d_xp;
    t_push              push;
    logic [2:0]         pend;
    logic [Q_AW:0]      q_count;
    t_result            head;

    assign o_cfg_ready = 1'b1;
    assign o_stall = (5'(q_count) + 5'(pend) + 5'd2) > 5'(Q_DEPTH);
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        if (r_size_x == '0) begin
            sx = XCW'(1);
        end else if (32'(r_size_x) > MAX_X) begin
            sx = XCW'(MAX_X);
        end else begin
            sx = XCW'(r_size_x);
        end
        if (r_size_y == '0) begin
            sy = YCW'(1);
        end else if (32'(r_size_y) > MAX_Y) begin
            sy = YCW'(MAX_Y);
        end else begin
            sy = YCW'(r_size_y);
        end
        sz = (r_size_z == '0) ? 12'd1 : r_size_z;
        bc = (r_batch_count == '0) ? 10'd1 : r_batch_count;

        x_end = (XCW'(r_x) + XCW'(1)) >= sx;
        y_end = (YCW'(r_y) + YCW'(1)) >= sy;
        z_end = ({1'b0, r_z} + 13'd1) >= {1'b0, sz};
        b_end = ({1'b0, r_batch} + 11'd1) >= {1'b0, bc};

        n_x     = x_end ? '0 : r_x + XW'(1);
        n_y     = r_y;
        n_z     = r_z;
        n_batch = r_batch;
        if (x_end) begin
            n_y = y_end ? '0 : r_y + YW'(1);
            if (y_end) begin
                n_z = z_end ? '0 : r_z + 12'd1;
                if (z_end) begin
                    n_batch = b_end ? '0 : r_batch + 10'd1;
                end
            end
        end

        // store is a two-plane ring chosen by z parity
        base     = AW'(r_y) * AW'(MAX_X) + AW'(r_x);
        cur_off  = r_z[0] ? AW'(PW) : '0;
        prev_off = r_z[0] ? '0 : AW'(PW);
        a_zm     = cur_off + base;
        a_c      = prev_off + base;
        a_ym     = a_c - AW'(MAX_X);
        a_yp     = a_c + AW'(MAX_X);
        a_xm     = a_c - AW'(1);
        a_xp     = a_c + AW'(1);

        meta.has0     = (r_z != '0);
        meta.has1     = z_end;
        meta.interior = (r_z >= 12'd2) && (r_z < sz) && (r_y != '0)
                      && ((YCW'(r_y) + YCW'(1)) < sy) && (r_x != '0)
                      && ((XCW'(r_x) + XCW'(1)) < sx);
        meta.cur      = i_point_value;
        meta.batch    = r_batch;
        meta.zc       = r_z - 12'd1;
        meta.z        = r_z;
        meta.y        = 6'(r_y);
        meta.x        = 6'(r_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x      <= 7'd64;
            r_size_y      <= 7'd64;
            r_size_z      <= 12'd64;
            r_batch_count <= 10'd1;
            r_x           <= '0;
            r_y           <= '0;
            r_z           <= '0;
            r_batch       <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SIZE_X: r_size_x      <= i_cfg_data[6:0];
                    CFG_SIZE_Y: r_size_y      <= i_cfg_data[6:0];
                    CFG_SIZE_Z: r_size_z      <= i_cfg_data;
                    CFG_BATCH:  r_batch_count <= i_cfg_data[9:0];
                    default:    r_size_x      <= r_size_x;
                endcase
            end
            if (accept) begin
                r_x     <= n_x;
                r_y     <= n_y;
                r_z     <= n_z;
                r_batch <= n_batch;
            end
        end
    end

    // three copies of the store, all written alike, two reads each
    jac3d_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_c (
        .i_clk(i_clk), .i_we(accept), .i_waddr(a_zm), .i_wdata(i_point_value),
        .i_raddr0(a_zm), .i_raddr1(a_c), .o_rdata0(d_zm), .o_rdata1(d_c)
    );
    jac3d_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_y (
        .i_clk(i_clk), .i_we(accept), .i_waddr(a_zm), .i_wdata(i_point_value),
        .i_raddr0(a_ym), .i_raddr1(a_yp), .o_rdata0(d_ym), .o_rdata1(d_yp)
    );
    jac3d_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_x (
        .i_clk(i_clk), .i_we(accept), .i_waddr(a_zm), .i_wdata(i_point_value),
        .i_raddr0(a_xm), .i_raddr1(a_xp), .o_rdata0(d_xm), .o_rdata1(d_xp)
    );

    jac3d_calc u_calc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_meta(meta),
        .i_zm(d_zm), .i_centre(d_c), .i_ym(d_ym), .i_yp(d_yp),
        .i_xm(d_xm), .i_xp(d_xp), .o_push(push), .o_pend(pend)
    );

    jac3d_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_valid(o_valid),
        .i_stall(i_stall), .o_head(head), .o_count(q_count)
    );

    assign o_out_value   = head.value;
    assign o_out_batch   = head.batch;
    assign o_out_z       = head.z;
    assign o_out_y       = head.y;
    assign o_out_x       = head.x;
    assign o_last_of_run = head.last;

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (32'(r_x) < MAX_X) && (32'(r_y) < MAX_Y))
        else $error("raster counter out of range");

endmodule
